// ----- rtl/scsd_pkg.sv -----
`timescale 1ns / 1ps

package scsd_pkg;

  // Fixed field widths of one token word and one result word.
  localparam int unsigned ClassW  = 4;
  localparam int unsigned CharW   = 8;
  localparam int unsigned LenW    = 8;
  localparam int unsigned LineNoW = 24;
  localparam int unsigned KindW   = 2;

  typedef enum logic [ClassW-1:0] {
    CL_OTHER  = 4'd0,
    CL_SEMI   = 4'd1,
    CL_LBRACE = 4'd2,
    CL_RBRACE = 4'd3,
    CL_LPAREN = 4'd4,
    CL_RPAREN = 4'd5,
    CL_IF     = 4'd6,
    CL_WHILE  = 4'd7,
    CL_FOR    = 4'd8,
    CL_DO     = 4'd9
  } tok_class_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_CLOSED = 3'd2,
    PH_SEMI   = 3'd3,
    PH_DOSKIP = 3'd5
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_IF    = 2'd0,
    KIND_WHILE = 2'd1,
    KIND_FOR   = 2'd2
  } stmt_kind_e;

  localparam logic [CharW-1:0] ChI = 8'h69;  // 'i'
  localparam logic [CharW-1:0] ChW = 8'h77;  // 'w'
  localparam logic [CharW-1:0] ChF = 8'h66;  // 'f'

  localparam logic [LenW-1:0] LenIf    = 8'd2;
  localparam logic [LenW-1:0] LenWhile = 8'd5;
  localparam logic [LenW-1:0] LenFor   = 8'd3;

  typedef struct packed {
    logic [ClassW-1:0]  tok_class;
    logic [CharW-1:0]   first_char;
    logic [LenW-1:0]    sym_len;
    logic [LineNoW-1:0] line_no;
  } tok_t;

  typedef struct packed {
    logic               warn;
    logic [LineNoW-1:0] warn_line;
    logic [KindW-1:0]   stmt_kind;
  } res_t;

endpackage

// ----- rtl/scsd_if.sv -----
`timescale 1ns / 1ps

// Token channel: one classified source token per word.
interface scsd_tok_if;
  logic                                valid;
  logic                                ready;
  logic [scsd_pkg::ClassW-1:0]         tok_class;
  logic [scsd_pkg::CharW-1:0]          first_char;
  logic [scsd_pkg::LenW-1:0]           sym_len;
  logic [scsd_pkg::LineNoW-1:0]        line_no;

  modport source (output valid, tok_class, first_char, sym_len, line_no, input ready);
  modport sink   (input valid, tok_class, first_char, sym_len, line_no, output ready);
endinterface

// Result channel: one result word per token.
interface scsd_res_if;
  logic                                valid;
  logic                                ready;
  logic                                warn;
  logic [scsd_pkg::LineNoW-1:0]        warn_line;
  logic [scsd_pkg::KindW-1:0]          stmt_kind;

  modport source (output valid, warn, warn_line, stmt_kind, input ready);
  modport sink   (input valid, warn, warn_line, stmt_kind, output ready);
endinterface

// ----- rtl/stray_semicolon_after_control_detector.sv -----
`timescale 1ns / 1ps

// Stray semicolon detector for control statements.
//
// tok_i carries one classified source token per word; res_o returns exactly
// one result word for every token, in order. A result word has warn set when
// its token is the opening brace of the pattern 'if/while/for ( ... ) ; {',
// with warn_line holding the line of the semicolon and stmt_kind the keyword
// (0 if, 1 while, 2 for); otherwise all of its fields are zero.
//
// The block is a two-register pipeline: a token word is captured in an input
// register, the next state and the result are formed in one pass of short
// logic, and the result is captured in an output register, from which it is
// presented. One token is taken every cycle as long as the receiver keeps
// res_o.ready high; the single tracker state update per token sets that rate.
//
// Reset clears the depth counters, the previous-token record and the phase
// machine, and empties both pipeline registers. When the receiver stalls,
// the output word holds, the input register fills behind it, and tok_i.ready
// drops only once both are full.
module stray_semicolon_after_control_detector #(
  parameter int unsigned DEPTH_WIDTH = 8,
  parameter int unsigned LINE_WIDTH  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scsd_tok_if.sink    tok_i,
  scsd_res_if.source  res_o
);

  logic            in_valid_q;
  scsd_pkg::tok_t  in_word_q;
  logic            out_valid_q;
  scsd_pkg::res_t  out_word_q;
  scsd_pkg::res_t  res_word;
  logic            advance;
  logic            take_in;

  // The input stage moves forward whenever the output register is free or
  // is being emptied in this cycle.
  assign advance = !out_valid_q || res_o.ready;
  assign take_in = tok_i.valid && tok_i.ready;

  assign tok_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tok_i.ready) begin
      in_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_word_q <= '{tok_class:  tok_i.tok_class,
                     first_char: tok_i.first_char,
                     sym_len:    tok_i.sym_len,
                     line_no:    tok_i.line_no};
    end
  end

  // The tracker state steps once for each word that leaves the input stage.
  scsd_core #(
    .DEPTH_WIDTH (DEPTH_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid_q && advance),
    .tok_i  (in_word_q),
    .res_o  (res_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_word_q <= res_word;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.warn      = out_word_q.warn;
  assign res_o.warn_line = out_word_q.warn_line;
  assign res_o.stmt_kind = out_word_q.stmt_kind;

  // A word in the input stage that moves on always lands in the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("word lost between input and output stage");

  // A blocked input stage keeps its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_word_q))
    else $error("input stage changed while blocked");

  // A result word without a warning carries no line and no kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_word_q.warn |-> (out_word_q.warn_line == '0) &&
                                        (out_word_q.stmt_kind == '0))
    else $error("quiet result word carries warning fields");

endmodule

// ----- rtl/scsd_core.sv -----
`timescale 1ns / 1ps

// Tracker state and the phase machine. The result is combinational from the
// current token and the state; the state advances when step_i is high.
module scsd_core #(
  parameter int unsigned DEPTH_WIDTH = 8,
  parameter int unsigned LINE_WIDTH  = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  scsd_pkg::tok_t  tok_i,
  output scsd_pkg::res_t  res_o
);

  localparam int unsigned LineNoW = scsd_pkg::LineNoW;

  scsd_pkg::phase_e                  phase_q, phase_d;
  logic [DEPTH_WIDTH-1:0]            paren_q, paren_d;
  logic [DEPTH_WIDTH-1:0]            brace_q, brace_d;
  logic [DEPTH_WIDTH-1:0]            paren_mark_q, paren_mark_d;
  logic [DEPTH_WIDTH-1:0]            do_mark_q, do_mark_d;
  logic [scsd_pkg::KindW-1:0]        kind_q, kind_d;
  scsd_pkg::tok_class_e              prev_class_q;
  logic [scsd_pkg::CharW-1:0]        prev_char_q;
  logic [scsd_pkg::LenW-1:0]         prev_len_q;
  logic [LINE_WIDTH-1:0]             prev_line_q;

  scsd_pkg::tok_class_e              cls;
  logic                              is_kw;
  logic                              do_open;
  logic                              len_bad;
  logic                              close_hit;
  logic [LINE_WIDTH+LineNoW-1:0]     line_in_ext;
  logic [LINE_WIDTH-1:0]             line_keep;
  logic [LINE_WIDTH+LineNoW-1:0]     line_out_ext;

  // Classes above the do code count as ordinary tokens.
  assign cls = (tok_i.tok_class > scsd_pkg::ClassW'(scsd_pkg::CL_DO)) ?
               scsd_pkg::CL_OTHER : scsd_pkg::tok_class_e'(tok_i.tok_class);

  assign is_kw   = (cls == scsd_pkg::CL_IF) || (cls == scsd_pkg::CL_WHILE) ||
                   (cls == scsd_pkg::CL_FOR);
  assign do_open = (prev_class_q == scsd_pkg::CL_DO) && (cls == scsd_pkg::CL_LBRACE);

  // A keyword text that starts like if/while/for but has the wrong length.
  always_comb begin
    case (prev_char_q)
      scsd_pkg::ChI: len_bad = (prev_len_q != scsd_pkg::LenIf);
      scsd_pkg::ChW: len_bad = (prev_len_q != scsd_pkg::LenWhile);
      scsd_pkg::ChF: len_bad = (prev_len_q != scsd_pkg::LenFor);
      default:       len_bad = 1'b0;
    endcase
  end

  // The header's own paren closes when the depth sits one above the mark.
  assign close_hit = ({1'b0, paren_q} == ({1'b0, paren_mark_q} + 1'b1));

  assign line_in_ext  = {{LINE_WIDTH{1'b0}}, tok_i.line_no};
  assign line_keep    = line_in_ext[LINE_WIDTH-1:0];
  assign line_out_ext = {{LineNoW{1'b0}}, prev_line_q};

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      scsd_pkg::PH_DOSKIP: begin
        if ((cls == scsd_pkg::CL_SEMI) && (do_mark_q == brace_q)) begin
          phase_d = scsd_pkg::PH_IDLE;
        end
      end
      scsd_pkg::PH_IDLE: begin
        if (do_open) begin
          phase_d = scsd_pkg::PH_DOSKIP;
        end else if (is_kw) begin
          phase_d = scsd_pkg::PH_HEADER;
        end
      end
      scsd_pkg::PH_HEADER: begin
        if ((cls == scsd_pkg::CL_LPAREN) && len_bad) begin
          phase_d = scsd_pkg::PH_IDLE;
        end else if ((cls == scsd_pkg::CL_RPAREN) && close_hit) begin
          phase_d = scsd_pkg::PH_CLOSED;
        end else if ((cls == scsd_pkg::CL_SEMI) &&
                     (kind_q != scsd_pkg::KindW'(scsd_pkg::KIND_FOR))) begin
          phase_d = scsd_pkg::PH_IDLE;
        end
      end
      scsd_pkg::PH_CLOSED: begin
        phase_d = (cls == scsd_pkg::CL_SEMI) ? scsd_pkg::PH_SEMI : scsd_pkg::PH_IDLE;
      end
      default: begin
        phase_d = scsd_pkg::PH_IDLE;
      end
    endcase
  end

  // Result word and the marks taken on leaving idle.
  always_comb begin
    res_o        = '0;
    do_mark_d    = do_mark_q;
    paren_mark_d = paren_mark_q;
    kind_d       = kind_q;
    if ((phase_q == scsd_pkg::PH_SEMI) && (cls == scsd_pkg::CL_LBRACE)) begin
      res_o.warn      = 1'b1;
      res_o.warn_line = line_out_ext[LineNoW-1:0];
      res_o.stmt_kind = kind_q;
    end
    if (phase_q == scsd_pkg::PH_IDLE) begin
      if (do_open) begin
        do_mark_d = brace_q;
      end else if (is_kw) begin
        paren_mark_d = paren_q;
        case (tok_i.first_char)
          scsd_pkg::ChI: kind_d = scsd_pkg::KIND_IF;
          scsd_pkg::ChW: kind_d = scsd_pkg::KIND_WHILE;
          scsd_pkg::ChF: kind_d = scsd_pkg::KIND_FOR;
          default:       kind_d = kind_q;
        endcase
      end
    end
  end

  // Depth counters clamp at zero and saturate at all ones.
  always_comb begin
    paren_d = paren_q;
    brace_d = brace_q;
    case (cls)
      scsd_pkg::CL_LBRACE: if (brace_q != '1) brace_d = brace_q + 1'b1;
      scsd_pkg::CL_RBRACE: if (brace_q != '0) brace_d = brace_q - 1'b1;
      scsd_pkg::CL_LPAREN: if (paren_q != '1) paren_d = paren_q + 1'b1;
      scsd_pkg::CL_RPAREN: if (paren_q != '0) paren_d = paren_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= scsd_pkg::PH_IDLE;
      paren_q      <= '0;
      brace_q      <= '0;
      paren_mark_q <= '0;
      do_mark_q    <= '0;
      kind_q       <= '0;
      prev_class_q <= scsd_pkg::CL_OTHER;
      prev_char_q  <= '0;
      prev_len_q   <= '0;
      prev_line_q  <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      paren_q      <= paren_d;
      brace_q      <= brace_d;
      paren_mark_q <= paren_mark_d;
      do_mark_q    <= do_mark_d;
      kind_q       <= kind_d;
      prev_class_q <= cls;
      prev_char_q  <= tok_i.first_char;
      prev_len_q   <= tok_i.sym_len;
      prev_line_q  <= line_keep;
    end
  end

  // A warning can only come out of the semicolon phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.warn |-> (phase_q == scsd_pkg::PH_SEMI))
    else $error("warning raised outside the semicolon phase");

  // The closed phase is entered only on a right paren.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == scsd_pkg::PH_HEADER) && (phase_d == scsd_pkg::PH_CLOSED)
    |-> (cls == scsd_pkg::CL_RPAREN))
    else $error("header closed without a right paren");

  // The kind register never holds the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q != 2'd3)
    else $error("statement kind register corrupted");

endmodule

// ----- sim/semi_warn_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the detector, predicts one result word per
// accepted token and compares the results in order.
module semi_warn_checker
  import scsd_pkg::*;
#(
  parameter int unsigned DEPTH_WIDTH = 8,
  parameter int unsigned LINE_WIDTH  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scsd_tok_if         tok_i,
  scsd_res_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned warn_count_o,
  output int unsigned result_count_o
);

  localparam int unsigned DepthMax = (1 << DEPTH_WIDTH) - 1;
  localparam logic [LineNoW-1:0] LineMask = LineNoW'((64'd1 << LINE_WIDTH) - 64'd1);
  localparam int unsigned ReportMax = 10;

  // Tracker state, kept the way the detector defines it.
  phase_e             phase_q;
  int unsigned        paren_cnt;
  int unsigned        brace_cnt;
  int unsigned        paren_base;
  int unsigned        do_base;
  stmt_kind_e         kind_q;
  tok_class_e         last_cls;
  logic [CharW-1:0]   last_char;
  logic [LenW-1:0]    last_len;
  logic [LineNoW-1:0] last_line;

  res_t        predicted_results[$];
  int unsigned fail_total;
  int unsigned pend_total;
  int unsigned warn_total;
  int unsigned result_total;

  assign fail_count_o   = fail_total;
  assign pending_o      = pend_total;
  assign warn_count_o   = warn_total;
  assign result_count_o = result_total;

  function automatic logic keyword_len_bad(input logic [CharW-1:0] ch,
                                           input logic [LenW-1:0] len);
    if (ch == ChI) return len != LenIf;
    if (ch == ChW) return len != LenWhile;
    if (ch == ChF) return len != LenFor;
    return 1'b0;
  endfunction

  task automatic predict_stray_semi(input tok_t t, output res_t r);
    tok_class_e         cls;
    logic [LineNoW-1:0] line;
    cls  = (t.tok_class > CL_DO) ? CL_OTHER : tok_class_e'(t.tok_class);
    line = t.line_no & LineMask;
    r    = '0;

    if (phase_q == PH_DOSKIP && cls == CL_SEMI && do_base == brace_cnt) begin
      phase_q = PH_IDLE;
    end else if (phase_q == PH_IDLE) begin
      if (last_cls == CL_DO && cls == CL_LBRACE) begin
        phase_q = PH_DOSKIP;
        do_base = brace_cnt;
      end else if (cls == CL_IF || cls == CL_WHILE || cls == CL_FOR) begin
        phase_q    = PH_HEADER;
        paren_base = paren_cnt;
        // An unexpected first byte leaves the kind from the last keyword.
        if (t.first_char == ChI) kind_q = KIND_IF;
        else if (t.first_char == ChW) kind_q = KIND_WHILE;
        else if (t.first_char == ChF) kind_q = KIND_FOR;
      end
    end else if (phase_q == PH_HEADER) begin
      if (cls == CL_LPAREN && keyword_len_bad(last_char, last_len)) begin
        phase_q = PH_IDLE;
      end else if (cls == CL_RPAREN && paren_cnt - paren_base == 1) begin
        phase_q = PH_CLOSED;
      end else if (cls == CL_SEMI && kind_q != KIND_FOR) begin
        phase_q = PH_IDLE;
      end
    end else if (phase_q == PH_CLOSED) begin
      phase_q = (cls == CL_SEMI) ? PH_SEMI : PH_IDLE;
    end else if (phase_q == PH_SEMI) begin
      if (cls == CL_LBRACE) begin
        r.warn      = 1'b1;
        r.warn_line = last_line;
        r.stmt_kind = kind_q;
      end
      phase_q = PH_IDLE;
    end

    case (cls)
      CL_LBRACE: if (brace_cnt < DepthMax) brace_cnt++;
      CL_RBRACE: if (brace_cnt > 0) brace_cnt--;
      CL_LPAREN: if (paren_cnt < DepthMax) paren_cnt++;
      CL_RPAREN: if (paren_cnt > 0) paren_cnt--;
      default: ;
    endcase

    last_cls  = cls;
    last_char = t.first_char;
    last_len  = t.sym_len;
    last_line = line;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tok_t tok_w;
    res_t exp_w;
    res_t got_w;
    if (!rst_ni) begin
      phase_q      = PH_IDLE;
      paren_cnt    = 0;
      brace_cnt    = 0;
      paren_base   = 0;
      do_base      = 0;
      kind_q       = KIND_IF;
      last_cls     = CL_OTHER;
      last_char    = '0;
      last_len     = '0;
      last_line    = '0;
      fail_total   = 0;
      pend_total   = 0;
      warn_total   = 0;
      result_total = 0;
      predicted_results.delete();
    end else begin
      if (tok_i.valid && tok_i.ready) begin
        tok_w = {tok_i.tok_class, tok_i.first_char, tok_i.sym_len, tok_i.line_no};
        predict_stray_semi(tok_w, exp_w);
        predicted_results.push_back(exp_w);
      end
      if (res_i.valid && res_i.ready) begin
        got_w = {res_i.warn, res_i.warn_line, res_i.stmt_kind};
        result_total++;
        if (got_w.warn === 1'b1) warn_total++;
        if (predicted_results.size() == 0) begin
          fail_total++;
          if (fail_total <= ReportMax)
            $display({"result word %0d arrived with nothing predicted: ",
                      "warn %0b line %06h kind %0d"},
                     result_total, got_w.warn, got_w.warn_line, got_w.stmt_kind);
        end else begin
          exp_w = predicted_results.pop_front();
          if (got_w.warn !== exp_w.warn || got_w.warn_line !== exp_w.warn_line ||
              got_w.stmt_kind !== exp_w.stmt_kind) begin
            fail_total++;
            if (fail_total <= ReportMax)
              $display({"result word %0d: expected warn %0b line %06h kind %0d, ",
                        "got warn %0b line %06h kind %0d"},
                       result_total, exp_w.warn, exp_w.warn_line, exp_w.stmt_kind,
                       got_w.warn, got_w.warn_line, got_w.stmt_kind);
          end
        end
      end
      pend_total = predicted_results.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the detector testbench. It makes the token stream and the output
// stall pattern, and it gives the verdict; all prediction and comparison
// lives in the checker instantiated beside the block.
module tb_top;
  import scsd_pkg::*;

  // A narrow depth counter lets ordinary nesting runs hit the saturation
  // limit, so the clamp at the top is exercised as well as the one at zero.
  localparam int unsigned DepthW       = 4;
  localparam int unsigned LineW        = 24;
  localparam int unsigned RandomTokens = 520;
  // Length of the long output hold-off, in cycles.
  localparam int unsigned LongHold     = 80;
  // Cycles allowed after the last result.
  localparam int unsigned DrainCycles  = 20;
  // Worst case is roughly 650 tokens plus the hold-offs; this leaves
  // a wide margin.
  localparam int unsigned CycleLimit   = 200000;

  // Output stall patterns, switched at random intervals.
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  scsd_tok_if tok_if ();
  scsd_res_if res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned warn_count;
  int unsigned result_count;

  int unsigned        tokens_sent;
  int unsigned        cycle_cnt;
  int unsigned        burst_left;
  int unsigned        hold_reqs;
  int unsigned        holds_done;
  logic               steady_run;
  logic [LineNoW-1:0] line_cur;

  stray_semicolon_after_control_detector #(
    .DEPTH_WIDTH(DepthW),
    .LINE_WIDTH (LineW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok_if),
    .res_o (res_if)
  );

  semi_warn_checker #(
    .DEPTH_WIDTH(DepthW),
    .LINE_WIDTH (LineW)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok_if),
    .res_i         (res_if),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .warn_count_o  (warn_count),
    .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Builds one token word for the directed part, where lines are chosen.
  function automatic tok_t mk_tok(input logic [ClassW-1:0] cls, input logic [CharW-1:0] ch,
                                  input logic [LenW-1:0] len, input logic [LineNoW-1:0] line);
    tok_t t;
    t.tok_class  = cls;
    t.first_char = ch;
    t.sym_len    = len;
    t.line_no    = line;
    return t;
  endfunction

  // Presents one word at the falling edge and holds it until the block takes
  // it. Valid is left high, so back-to-back words need no extra edge.
  task automatic send_token(input tok_t t);
    @(negedge clk_i);
    tok_if.valid      = 1'b1;
    tok_if.tok_class  = t.tok_class;
    tok_if.first_char = t.first_char;
    tok_if.sym_len    = t.sym_len;
    tok_if.line_no    = t.line_no;
    @(posedge clk_i);
    while (!tok_if.ready) @(posedge clk_i);
    tokens_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      tok_if.valid = 1'b0;
    end
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic drain_wait();
    @(negedge clk_i);
    tok_if.valid = 1'b0;
    wait (pending == 0);
  endtask

  // Random-part sender: words go out in bursts with gaps between them, except
  // during steady runs. Line numbers mostly creep upward like real source and
  // now and then jump anywhere in the 24-bit range.
  task automatic emit(input logic [ClassW-1:0] cls, input logic [CharW-1:0] ch,
                      input logic [LenW-1:0] len);
    tok_t t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_run) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
    if ($urandom_range(0, 15) == 0) line_cur = LineNoW'($urandom());
    else line_cur += LineNoW'($urandom_range(0, 2));
    t.tok_class  = cls;
    t.first_char = ch;
    t.sym_len    = len;
    t.line_no    = line_cur;
    send_token(t);
  endtask

  // Any word at all, including the unused class codes above do.
  task automatic emit_any();
    emit(ClassW'($urandom_range(0, 15)), CharW'($urandom_range(0, 255)),
         LenW'($urandom_range(0, 255)));
  endtask

  // A control statement 'kw ( ... ) ; {' with random content. Most are well
  // formed enough to reach the semicolon check; some carry an odd first byte,
  // a wrong keyword length, or a broken tail.
  task automatic seq_control();
    stmt_kind_e        kw;
    int unsigned       n;
    logic [ClassW-1:0] kw_cls;
    logic [CharW-1:0]  kw_ch;
    logic [LenW-1:0]   kw_len;
    kw = stmt_kind_e'($urandom_range(0, 2));
    case (kw)
      KIND_IF: begin
        kw_cls = CL_IF;
        kw_ch  = ChI;
        kw_len = LenIf;
      end
      KIND_WHILE: begin
        kw_cls = CL_WHILE;
        kw_ch  = ChW;
        kw_len = LenWhile;
      end
      default: begin
        kw_cls = CL_FOR;
        kw_ch  = ChF;
        kw_len = LenFor;
      end
    endcase
    if ($urandom_range(0, 9) == 0) kw_ch = CharW'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) kw_len = LenW'($urandom_range(0, 7));
    emit(kw_cls, kw_ch, kw_len);
    if ($urandom_range(0, 9) == 0) emit_any();
    emit(CL_LPAREN, "(", 8'd1);
    n = $urandom_range(0, 3);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: emit(CL_OTHER, "x", 8'd1);
        1: begin
          // Nested parens must not close the header early.
          emit(CL_LPAREN, "(", 8'd1);
          emit(CL_OTHER, "n", LenW'($urandom_range(1, 8)));
          emit(CL_RPAREN, ")", 8'd1);
        end
        2: emit(CL_SEMI, ";", 8'd1);
        default: emit(CL_OTHER, CharW'($urandom_range(33, 126)), LenW'($urandom_range(1, 12)));
      endcase
    end
    emit(CL_RPAREN, ")", 8'd1);
    if ($urandom_range(0, 9) < 7) emit(CL_SEMI, ";", 8'd1);
    else emit_any();
    if ($urandom_range(0, 9) < 7) emit(CL_LBRACE, "{", 8'd1);
    else emit_any();
    if ($urandom_range(0, 1) == 1) begin
      emit(CL_OTHER, "y", 8'd1);
      emit(CL_SEMI, ";", 8'd1);
      emit(CL_RBRACE, "}", 8'd1);
    end
  endtask

  // A braced do-block ending in 'while (...);'. The body holds semicolons at
  // deeper brace levels and control keywords, none of which may end the skip.
  task automatic seq_do();
    int unsigned n;
    emit(CL_DO, "d", 8'd2);
    if ($urandom_range(0, 9) < 9) emit(CL_LBRACE, "{", 8'd1);
    else emit_any();
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin
          emit(CL_OTHER, "z", 8'd1);
          emit(CL_SEMI, ";", 8'd1);
        end
        1: begin
          emit(CL_LBRACE, "{", 8'd1);
          emit(CL_SEMI, ";", 8'd1);
          emit(CL_RBRACE, "}", 8'd1);
        end
        2: begin
          emit(CL_IF, ChI, LenIf);
          emit(CL_LPAREN, "(", 8'd1);
          emit(CL_RPAREN, ")", 8'd1);
          emit(CL_SEMI, ";", 8'd1);
        end
        default: emit(CL_SEMI, ";", 8'd1);
      endcase
    end
    emit(CL_RBRACE, "}", 8'd1);
    emit(CL_WHILE, ChW, LenWhile);
    emit(CL_LPAREN, "(", 8'd1);
    emit(CL_OTHER, "c", 8'd1);
    emit(CL_RPAREN, ")", 8'd1);
    emit(CL_SEMI, ";", 8'd1);
  endtask

  // A run of openers and a slightly longer run of closers: with the narrow
  // depth counter this saturates at the top and clamps at zero.
  task automatic seq_nest();
    int unsigned       n;
    logic [ClassW-1:0] opener;
    logic [ClassW-1:0] closer;
    if ($urandom_range(0, 1) == 1) begin
      opener = CL_LPAREN;
      closer = CL_RPAREN;
    end else begin
      opener = CL_LBRACE;
      closer = CL_RBRACE;
    end
    n = $urandom_range(1, 20);
    repeat (n) emit(opener, "o", 8'd1);
    emit(CL_OTHER, "m", 8'd1);
    repeat (n + $urandom_range(0, 3)) emit(closer, "c", 8'd1);
  endtask

  // Asks the receiver for its long hold-off and keeps offering words with no
  // gaps, so the block fills both registers and drops its input ready.
  task automatic flood_under_hold();
    logic keep;
    keep       = steady_run;
    hold_reqs++;
    steady_run = 1'b1;
    repeat (3) seq_control();
    steady_run = keep;
  endtask

  // The directed part: a warning for if and for (the latter with semicolons
  // inside its header), a keyword with an odd first byte that keeps the
  // earlier kind, a broken pattern after the closing paren, a keyword length
  // mismatch, a skipped do-block, an unknown class code, a semicolon in an if
  // header, and the extremes of every field.
  task automatic run_directed();
    send_token(mk_tok(CL_IF, ChI, LenIf, 24'h000000));
    send_token(mk_tok(CL_LPAREN, "(", 8'd1, 24'h000001));
    send_token(mk_tok(CL_RPAREN, ")", 8'd1, 24'h000001));
    send_token(mk_tok(CL_SEMI, ";", 8'd1, 24'hFFFFFF));
    send_token(mk_tok(CL_LBRACE, "{", 8'd1, 24'h000002));
    send_token(mk_tok(CL_RBRACE, "}", 8'd1, 24'h000003));
    send_token(mk_tok(CL_FOR, ChF, LenFor, 24'h000010));
    send_token(mk_tok(CL_LPAREN, "(", 8'd1, 24'h000010));
    send_token(mk_tok(CL_SEMI, ";", 8'd1, 24'h000010));
    send_token(mk_tok(CL_RPAREN, ")", 8'd1, 24'h000010));
    send_token(mk_tok(CL_SEMI, ";", 8'd1, 24'hA5A5A5));
    send_token(mk_tok(CL_LBRACE, "{", 8'd1, 24'h5A5A5A));
    send_token(mk_tok(CL_RBRACE, "}", 8'd1, 24'h000011));
    send_token(mk_tok(CL_WHILE, 8'h00, 8'hFF, 24'h000020));
    send_token(mk_tok(CL_LPAREN, "(", 8'd1, 24'h000020));
    send_token(mk_tok(CL_RPAREN, ")", 8'd1, 24'h000020));
    send_token(mk_tok(CL_OTHER, "x", 8'd1, 24'h000020));
    send_token(mk_tok(CL_WHILE, ChW, 8'd4, 24'h000030));
    send_token(mk_tok(CL_LPAREN, "(", 8'd1, 24'h000030));
    send_token(mk_tok(CL_DO, "d", 8'd2, 24'h000040));
    send_token(mk_tok(CL_LBRACE, "{", 8'd1, 24'h000040));
    send_token(mk_tok(CL_IF, ChI, LenIf, 24'h000041));
    send_token(mk_tok(CL_RBRACE, "}", 8'd1, 24'h000042));
    send_token(mk_tok(CL_SEMI, ";", 8'd1, 24'h000042));
    send_token(mk_tok(4'd15, 8'hFF, 8'h00, 24'hFFFFFF));
    send_token(mk_tok(CL_IF, ChI, LenIf, 24'h000050));
    send_token(mk_tok(CL_SEMI, ";", 8'd1, 24'h000050));
  endtask

  // Receiver: ready changes at the falling edge, following one of several
  // stall patterns for a random stretch. A hold-off request from the sender
  // side is served here and counted in this process.
  initial begin : result_ready
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned tick;
    res_if.ready = 1'b0;
    holds_done   = 0;
    mode         = RX_OPEN;
    mode_left    = 0;
    tick         = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_reqs) begin
        res_if.ready = 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:     res_if.ready = 1'b1;
          RX_COIN:     res_if.ready = 1'($urandom_range(0, 1));
          RX_PERIODIC: res_if.ready = (tick % 4) != 3;
          default:     res_if.ready = $urandom_range(0, 9) < 2;
        endcase
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("run stopped by the cycle limit of %0d", CycleLimit);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned directed_n;
    int unsigned pick;
    logic        mid_flood;
    rst_ni            = 1'b0;
    tok_if.valid      = 1'b0;
    tok_if.tok_class  = '0;
    tok_if.first_char = '0;
    tok_if.sym_len    = '0;
    tok_if.line_no    = '0;
    tokens_sent       = 0;
    burst_left        = 0;
    hold_reqs         = 0;
    steady_run        = 1'b0;
    line_cur          = '0;
    mid_flood         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    directed_n = tokens_sent;
    // Sender pauses here until every predicted result has come back.
    drain_wait();

    // The random part opens with the block stalled at the output.
    flood_under_hold();
    while (tokens_sent < directed_n + RandomTokens) begin
      if (!mid_flood && tokens_sent >= directed_n + RandomTokens / 2) begin
        mid_flood = 1'b1;
        flood_under_hold();
      end
      if ($urandom_range(0, 19) == 0) steady_run = !steady_run;
      if ($urandom_range(0, 49) == 0) drain_wait();
      pick = $urandom_range(0, 99);
      if (pick < 50) seq_control();
      else if (pick < 65) seq_do();
      else if (pick < 78) seq_nest();
      else repeat ($urandom_range(1, 4)) emit_any();
    end

    drain_wait();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d tokens and %0d result words, %0d of them warnings, %0d output hold-offs",
             tokens_sent, result_count, warn_count, holds_done);
    $display("depth counters ran %0d bits wide, so nesting runs hit both clamps", DepthW);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
